### rtl/core/gpb_pkg.sv
// Shared types and constants for the GPIO port register bank.
package gpb_pkg;

  localparam int ADDR_W     = 14;
  localparam int SLOT_W     = 10;
  localparam int PORT_SEL_W = 3;
  localparam int PINS       = 16;
  localparam int WORD_W     = 32;
  localparam int SIZE_W     = 3;

  localparam int NUM_PORTS_DEF         = 4;
  localparam int PORT_REGION_START_DEF = 2048;

  localparam logic [WORD_W-1:0] MODE_RESET   = 32'h4444_4444;
  localparam logic [PINS-1:0]   LEVELS_RESET = 16'hffff;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_PINS  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [SLOT_W-1:0] REG_MODE_LO  = 10'h000;
  localparam logic [SLOT_W-1:0] REG_MODE_HI  = 10'h004;
  localparam logic [SLOT_W-1:0] REG_INPUT    = 10'h008;
  localparam logic [SLOT_W-1:0] REG_LATCH    = 10'h00c;
  localparam logic [SLOT_W-1:0] REG_SETRESET = 10'h010;
  localparam logic [SLOT_W-1:0] REG_CLEAR    = 10'h014;
  localparam logic [SLOT_W-1:0] REG_LOCK     = 10'h018;

  localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;

  // Decoded request handed to the register bank
  typedef struct packed {
    logic                  wr;
    logic                  pin;
    logic [PORT_SEL_W-1:0] port;
    logic [SLOT_W-1:0]     roff;
  } bank_req_t;

endpackage

### rtl/core/gpb_port_bank.sv
// Per-port register storage, update logic and read selection.
module gpb_port_bank import gpb_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bank_req_t         req,
  input  logic [WORD_W-1:0] write_data,
  input  logic [PINS-1:0]   pin_levels,
  output logic [WORD_W-1:0] rd_word
);

  logic [WORD_W-1:0] mode_lo   [NUM_PORTS];
  logic [WORD_W-1:0] mode_hi   [NUM_PORTS];
  logic [PINS-1:0]   latch     [NUM_PORTS];
  logic [WORD_W-1:0] lock      [NUM_PORTS];
  logic [PINS-1:0]   levels    [NUM_PORTS];
  logic [WORD_W-1:0] port_word [NUM_PORTS];

  for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
    logic            sel;
    logic [PINS-1:0] drive;
    logic [PINS-1:0] view;

    assign sel = (req.port == PORT_SEL_W'(p));

    always_ff @(posedge clk) begin
      if (rst) begin
        mode_lo[p] <= MODE_RESET;
        mode_hi[p] <= MODE_RESET;
        latch[p]   <= '0;
        lock[p]    <= '0;
        levels[p]  <= LEVELS_RESET;
      end else if (req.wr && sel) begin
        case (req.roff)
          REG_MODE_LO:  mode_lo[p] <= write_data;
          REG_MODE_HI:  mode_hi[p] <= write_data;
          REG_LATCH:    latch[p]   <= write_data[PINS-1:0];
          REG_SETRESET: latch[p]   <= (latch[p] | write_data[PINS-1:0])
                                      & ~write_data[WORD_W-1:PINS];
          REG_CLEAR:    latch[p]   <= latch[p] & ~write_data[PINS-1:0];
          REG_LOCK:     lock[p]    <= write_data;
          default:      ;
        endcase
      end else if (req.pin && sel) begin
        levels[p] <= pin_levels;
      end
    end

    // A pin drives when the low two bits of its mode nibble are nonzero
    always_comb begin
      for (int i = 0; i < PINS / 2; i++) begin
        drive[i]            = |mode_lo[p][4*i +: 2];
        drive[i + PINS / 2] = |mode_hi[p][4*i +: 2];
      end
    end

    assign view = (latch[p] & drive) | (levels[p] & ~drive);

    always_comb begin
      case (req.roff)
        REG_MODE_LO: port_word[p] = mode_lo[p];
        REG_MODE_HI: port_word[p] = mode_hi[p];
        REG_INPUT:   port_word[p] = {{(WORD_W-PINS){1'b0}}, view};
        REG_LATCH:   port_word[p] = {{(WORD_W-PINS){1'b0}}, latch[p]};
        REG_LOCK:    port_word[p] = lock[p];
        default:     port_word[p] = '0;
      endcase
    end
  end

  always_comb begin
    rd_word = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (req.port == PORT_SEL_W'(p)) rd_word = rd_word | port_word[p];
    end
  end

endmodule

### rtl/core/gpio_port_register_bank_top.sv
// Top level of the GPIO port register bank: input stage, decode, result register.
//
// Items arrive on the input channel (in_valid/in_ready) as a kind, a byte
// address, an access size, write data and pin levels. Kind read returns the
// addressed register, lane-selected by access size; kind write updates the
// mode words, output latch (direct, set/reset, clear) or lock word; kind pin
// update loads the external levels of the addressed port. Every item gives
// exactly one result on the output channel (out_valid/out_ready); it is zero
// for anything but a read that hits a port register.
// An accepted item is held in the input register, where it is decoded and
// applied, and its result is then registered in the output register;
// throughput is one item per cycle while the receiver keeps out_ready high,
// set by the single decode-and-update pass.
// Reset returns every port to mode 0x44444444, latch and lock zero and pin
// levels all ones, and empties both stages. When the receiver stalls, the
// result holds in the output register, one more item waits in the input
// register and in_ready drops after that.
module gpio_port_register_bank_top import gpb_pkg::*; #(
  parameter int NUM_PORTS         = NUM_PORTS_DEF,
  parameter int PORT_REGION_START = PORT_REGION_START_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [ADDR_W-1:0] address,
  input  logic [SIZE_W-1:0] access_size,
  input  logic [WORD_W-1:0] write_data,
  input  logic [PINS-1:0]   pin_levels,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] read_data
);

  localparam logic [ADDR_W-1:0]     REGION_BASE = ADDR_W'(PORT_REGION_START);
  localparam logic [PORT_SEL_W+1:0] PORT_LIMIT  = (PORT_SEL_W+2)'(NUM_PORTS);

  logic              s1_valid;
  kind_t             s1_kind;
  logic [ADDR_W-1:0] s1_address;
  logic [SIZE_W-1:0] s1_size;
  logic [WORD_W-1:0] s1_wdata;
  logic [PINS-1:0]   s1_pins;

  logic                      adv;
  logic                      s1_fire;
  logic [ADDR_W-1:0]         addr_rel;
  logic [ADDR_W-SLOT_W-1:0]  port_raw;
  logic                      s1_hit;
  bank_req_t                 req;
  logic [WORD_W-1:0]         rd_word;
  logic [WORD_W-1:0]         lane_word;
  logic [WORD_W-1:0]         read_data_next;

  assign adv      = !out_valid || out_ready;
  assign s1_fire  = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload needs no reset; load on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind    <= kind_t'(kind);
      s1_address <= address;
      s1_size    <= access_size;
      s1_wdata   <= write_data;
      s1_pins    <= pin_levels;
    end
  end

  assign addr_rel = s1_address - REGION_BASE;
  assign port_raw = addr_rel[ADDR_W-1:SLOT_W];
  assign s1_hit   = (s1_address >= REGION_BASE)
                    && ({{(PORT_SEL_W+2-(ADDR_W-SLOT_W)){1'b0}}, port_raw} < PORT_LIMIT);

  always_comb begin
    req.wr   = s1_fire && s1_hit && (s1_kind == KIND_WRITE);
    req.pin  = s1_fire && s1_hit && (s1_kind == KIND_PINS);
    req.port = port_raw[PORT_SEL_W-1:0];
    req.roff = addr_rel[SLOT_W-1:0];
  end

  gpb_port_bank #(
    .NUM_PORTS (NUM_PORTS)
  ) u_bank (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .write_data (s1_wdata),
    .pin_levels (s1_pins),
    .rd_word    (rd_word)
  );

  // Byte reads pick the addressed lane, halfword reads the low half
  always_comb begin
    case (s1_size)
      SIZE_BYTE: lane_word = {24'd0, 8'(rd_word >> {req.roff[1:0], 3'b000})};
      SIZE_HALF: lane_word = {16'd0, rd_word[15:0]};
      default:   lane_word = rd_word;
    endcase
    read_data_next = (s1_hit && (s1_kind == KIND_READ)) ? lane_word : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_data <= read_data_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while a stage was free");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_kind != KIND_READ) |=> (out_valid && read_data == '0))
    else $error("non-read item gave a nonzero result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_hit) |=> (read_data == '0))
    else $error("access outside the ports gave a nonzero result");

  a_no_update_without_fire: assert property (@(posedge clk) disable iff (rst)
    (req.wr || req.pin) |-> (s1_valid && adv && s1_hit))
    else $error("register update without an item in flight");

endmodule

### dv/tb_gpio_port_register_bank_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GPIO port register bank: directed table, then random items.
module tb_gpio_port_register_bank_top;
  import gpb_pkg::*;

  localparam int NUM_PORTS         = NUM_PORTS_DEF;
  localparam int PORT_REGION_START = PORT_REGION_START_DEF;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLD_AT        = 1200;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  access_size;
    logic [WORD_W-1:0]  write_data;
    logic [PINS-1:0]    pin_levels;
    bit                 typed;
    logic [WORD_W-1:0]  read_data;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind = '0;
  logic [ADDR_W-1:0] address = '0;
  logic [SIZE_W-1:0] access_size = '0;
  logic [WORD_W-1:0] write_data = '0;
  logic [PINS-1:0]   pin_levels = '0;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] read_data;

  // Model of the port state
  logic [WORD_W-1:0] port_mode_lo [NUM_PORTS];
  logic [WORD_W-1:0] port_mode_hi [NUM_PORTS];
  logic [PINS-1:0]   port_latch   [NUM_PORTS];
  logic [WORD_W-1:0] port_lock    [NUM_PORTS];
  logic [PINS-1:0]   port_levels  [NUM_PORTS];

  stim_row_t         stim [$];
  logic [WORD_W-1:0] pending_read_data [$];
  logic [WORD_W-1:0] offered_read_data = '0;
  int                mismatches = 0;
  int                idle_cycles = 0;

  gpio_port_register_bank_top #(
    .NUM_PORTS         (NUM_PORTS),
    .PORT_REGION_START (PORT_REGION_START)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .address     (address),
    .access_size (access_size),
    .write_data  (write_data),
    .pin_levels  (pin_levels),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] slot_addr(int port, logic [SLOT_W-1:0] roff);
    return ADDR_W'(PORT_REGION_START + port * 1024 + int'(roff));
  endfunction

  // Apply one item to the port model and return its read data
  function automatic logic [WORD_W-1:0] predict_read_data(stim_row_t item);
    int                rel;
    int                p;
    logic [SLOT_W-1:0] roff;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mode;
    logic [PINS-1:0]   drive;
    logic [3:0]        nib;
    if (int'(item.address) < PORT_REGION_START) return '0;
    rel  = int'(item.address) - PORT_REGION_START;
    p    = rel >> SLOT_W;
    roff = rel[SLOT_W-1:0];
    if (p >= NUM_PORTS) return '0;
    case (item.kind)
      KIND_READ: begin
        for (int i = 0; i < PINS; i++) begin
          mode = (i < 8) ? port_mode_lo[p] : port_mode_hi[p];
          nib = mode[(i % 8) * 4 +: 4];
          drive[i] = (nib[1:0] != 2'b00);
        end
        case (roff)
          REG_MODE_LO: word = port_mode_lo[p];
          REG_MODE_HI: word = port_mode_hi[p];
          REG_INPUT:   word = {16'h0, (port_latch[p] & drive) | (port_levels[p] & ~drive)};
          REG_LATCH:   word = {16'h0, port_latch[p]};
          REG_LOCK:    word = port_lock[p];
          default:     word = '0;
        endcase
        if (item.access_size == SIZE_BYTE) return (word >> (roff[1:0] * 8)) & 32'hff;
        if (item.access_size == SIZE_HALF) return word & 32'hffff;
        return word;
      end
      KIND_WRITE: begin
        case (roff)
          REG_MODE_LO:  port_mode_lo[p] = item.write_data;
          REG_MODE_HI:  port_mode_hi[p] = item.write_data;
          REG_LATCH:    port_latch[p] = item.write_data[15:0];
          REG_SETRESET: port_latch[p] = (port_latch[p] | item.write_data[15:0])
                                        & ~item.write_data[31:16];
          REG_CLEAR:    port_latch[p] = port_latch[p] & ~item.write_data[15:0];
          REG_LOCK:     port_lock[p] = item.write_data;
          default: ;
        endcase
      end
      KIND_PINS: port_levels[p] = item.pin_levels;
      default: ;
    endcase
    return '0;
  endfunction

  task automatic push_row(kind_t k, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
                          logic [WORD_W-1:0] w, logic [PINS-1:0] pins,
                          bit typed, logic [WORD_W-1:0] rd);
    stim_row_t row;
    row.kind = k;
    row.address = a;
    row.access_size = s;
    row.write_data = w;
    row.pin_levels = pins;
    row.typed = typed;
    row.read_data = rd;
    stim.push_back(row);
  endtask

  // Result checking, expectation capture and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_read_data.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %08h", $time, read_data);
          mismatches = mismatches + 1;
        end else if (pending_read_data[0] !== read_data) begin
          $display("%0t: read_data mismatch, expected %08h, actual %08h",
                   $time, pending_read_data[0], read_data);
          mismatches = mismatches + 1;
          void'(pending_read_data.pop_front());
        end else begin
          void'(pending_read_data.pop_front());
        end
      end
      if (in_valid && in_ready) pending_read_data.push_back(offered_read_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("tb_gpio_port_register_bank_top NOT OK");
        $finish;
      end
    end
  end

  // Receiver: stall phases of varying density, one long hold-off
  initial begin
    int recv_cycle;
    int stall_pct;
    recv_cycle = 0;
    stall_pct = 0;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      recv_cycle++;
      if (recv_cycle == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (recv_cycle % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    stim_row_t         row;
    logic [WORD_W-1:0] predicted;
    int                burst_left;
    int                gap;
    int                r;
    logic [SLOT_W-1:0] reg_offsets [7];

    reg_offsets = '{REG_MODE_LO, REG_MODE_HI, REG_INPUT, REG_LATCH,
                    REG_SETRESET, REG_CLEAR, REG_LOCK};
    for (int p = 0; p < NUM_PORTS; p++) begin
      port_mode_lo[p] = MODE_RESET;
      port_mode_hi[p] = MODE_RESET;
      port_latch[p]   = '0;
      port_lock[p]    = '0;
      port_levels[p]  = LEVELS_RESET;
    end

    // Reset values, region edges, every register, lanes and ignored accesses
    push_row(KIND_READ,  slot_addr(0, REG_MODE_LO), SIZE_WORD, '0, '0, 1, 32'h4444_4444);
    push_row(KIND_READ,  slot_addr(0, REG_MODE_HI), SIZE_WORD, '0, '0, 1, 32'h4444_4444);
    push_row(KIND_READ,  slot_addr(0, REG_INPUT),   SIZE_WORD, '0, '0, 1, 32'h0000_ffff);
    push_row(KIND_READ,  slot_addr(3, REG_LATCH),   SIZE_WORD, '0, '0, 1, '0);
    push_row(KIND_READ,  slot_addr(3, REG_LOCK),    SIZE_WORD, '0, '0, 1, '0);
    push_row(KIND_READ,  14'h0000, SIZE_WORD, '0, '0, 1, '0);
    push_row(KIND_WRITE, 14'h07fc, SIZE_WORD, 32'hffff_ffff, '0, 1, '0);
    push_row(KIND_READ,  14'h07fc, 3'd0, '0, '0, 1, '0);
    push_row(KIND_WRITE, slot_addr(NUM_PORTS, REG_MODE_LO), SIZE_WORD, '0, '0, 1, '0);
    push_row(KIND_READ,  slot_addr(NUM_PORTS, REG_MODE_LO), SIZE_WORD, '0, '0, 1, '0);
    push_row(KIND_READ,  14'h3fff, 3'd7, '0, '0, 1, '0);
    push_row(KIND_WRITE, slot_addr(0, REG_MODE_LO), SIZE_WORD, 32'h3333_3333, '0, 1, '0);
    push_row(KIND_WRITE, slot_addr(0, REG_LATCH), SIZE_BYTE, 32'hffff_ffff, '0, 1, '0);
    push_row(KIND_READ,  slot_addr(0, REG_INPUT), SIZE_WORD, '0, '0, 0, '0);
    push_row(KIND_WRITE, slot_addr(0, REG_SETRESET), SIZE_WORD, 32'h00ff_0f00, '0, 0, '0);
    push_row(KIND_READ,  slot_addr(0, REG_LATCH), SIZE_WORD, '0, '0, 0, '0);
    push_row(KIND_WRITE, slot_addr(0, REG_CLEAR), SIZE_HALF, 32'hffff_00f0, '0, 0, '0);
    push_row(KIND_READ,  slot_addr(0, REG_LATCH), SIZE_HALF, '0, '0, 0, '0);
    push_row(KIND_WRITE, slot_addr(0, REG_INPUT), SIZE_WORD, '0, '0, 0, '0);
    push_row(KIND_READ,  slot_addr(0, REG_SETRESET), SIZE_WORD, '0, '0, 1, '0);
    push_row(KIND_PINS,  slot_addr(1, 10'h3ff), SIZE_WORD, '0, 16'h0000, 1, '0);
    push_row(KIND_PINS,  14'h0100, SIZE_WORD, '0, 16'h0000, 1, '0);
    push_row(KIND_READ,  slot_addr(1, REG_INPUT), SIZE_HALF, '0, '0, 1, '0);
    push_row(KIND_NONE,  slot_addr(0, REG_MODE_LO), SIZE_WORD, 32'hffff_ffff, '1, 1, '0);
    push_row(KIND_WRITE, slot_addr(3, REG_LOCK), SIZE_WORD, 32'hdead_beef, '0, 0, '0);
    push_row(KIND_READ,  slot_addr(3, REG_LOCK), SIZE_BYTE, '0, '0, 0, '0);
    push_row(KIND_READ,  slot_addr(3, REG_LOCK), SIZE_HALF, '0, '0, 0, '0);

    // Mostly aligned register accesses on real ports, mixed with stray offsets and addresses
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      row.kind = (r < 45) ? KIND_READ : (r < 85) ? KIND_WRITE : (r < 96) ? KIND_PINS : KIND_NONE;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        row.address = slot_addr($urandom_range(0, NUM_PORTS - 1),
                                reg_offsets[$urandom_range(0, 6)]);
      end else if (r < 88) begin
        row.address = slot_addr($urandom_range(0, NUM_PORTS - 1),
                                SLOT_W'($urandom_range(0, 1023)));
      end else begin
        row.address = ADDR_W'($urandom_range(0, 16383));
      end
      r = $urandom_range(0, 9);
      row.access_size = (r < 3) ? SIZE_BYTE : (r < 6) ? SIZE_HALF :
                        (r < 8) ? SIZE_WORD : SIZE_W'($urandom_range(0, 7));
      row.write_data = $urandom;
      row.pin_levels = PINS'($urandom_range(0, 65535));
      row.typed = 0;
      row.read_data = '0;
      stim.push_back(row);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    burst_left = $urandom_range(1, 20);
    foreach (stim[i]) begin
      row = stim[i];
      predicted = predict_read_data(row);
      kind <= row.kind;
      address <= row.address;
      access_size <= row.access_size;
      write_data <= row.write_data;
      pin_levels <= row.pin_levels;
      offered_read_data <= row.typed ? row.read_data : predicted;
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
    in_valid <= 1'b0;

    // Let the last accepted item reach the expectation queue
    @(posedge clk);
    while (pending_read_data.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_read_data.size() == 0) begin
      $display("tb_gpio_port_register_bank_top OK");
    end else begin
      $display("tb_gpio_port_register_bank_top NOT OK");
    end
    $finish;
  end

endmodule
